### hw/rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the sprite screen projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH   = 3'd0,
    CFG_SCREEN_HEIGHT  = 3'd1,
    CFG_VERTICAL_MOVE  = 3'd2,
    CFG_WIDTH_DIVISOR  = 3'd3,
    CFG_HEIGHT_DIVISOR = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] view_dir_x;
    logic signed [31:0] view_dir_y;
    logic signed [31:0] cam_plane_x;
    logic signed [31:0] cam_plane_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] center_column;
    logic signed [15:0] vertical_shift;
    logic        [14:0] height_px;
    logic        [14:0] width_px;
    logic        [14:0] top_row;
    logic signed [15:0] bottom_row;
    logic        [14:0] left_col;
    logic signed [15:0] right_col;
    logic signed [31:0] depth;
    logic               visible;
  } out_t;

endpackage

`default_nettype wire

### hw/rtl/ssp_delay.sv
// ----------------------------------------------------------------------------
// ssp_delay
// Shift line that carries side data alongside a divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] d_o
);

  logic [W-1:0] d_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        d_q[i] <= d_q[i-1];
      end
    end
  end

  assign d_o = d_q[N-1];

endmodule

`default_nettype wire

### hw/rtl/ssp_div.sv
// ----------------------------------------------------------------------------
// ssp_div
// Pipelined restoring divider, one quotient bit per stage, with a signed
// saturated result of QW bits and truncation toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_div #(
  parameter int NW = 80,
  parameter int DW = 64,
  parameter int QW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic          neg_i,
  output logic               valid_o,
  output logic signed [QW-1:0] res_o
);

  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0] rem_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic          neg_q  [QW+1];
  logic          over_q [QW+1];
  logic          v_q    [QW+1];

  logic          over_d;

  // quotient would not fit in QW bits
  assign over_d = CW'(num_i) >= (CW'(den_i) << QW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      neg_q[0]  <= neg_i;
      over_q[0] <= over_d;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [CW-1:0] trial;
    logic          ge;

    assign trial = CW'(den_q[k]) << B;
    assign ge    = CW'(rem_q[k]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? NW'(CW'(rem_q[k]) - trial) : rem_q[k];
        quo_q[k+1]  <= quo_q[k] | (ge ? (QW'(1) << B) : '0);
        den_q[k+1]  <= den_q[k];
        neg_q[k+1]  <= neg_q[k];
        over_q[k+1] <= over_q[k];
      end
    end
  end

  logic [QW-1:0] q;
  logic          big_pos;
  logic          big_neg;

  assign q       = quo_q[QW];
  assign big_pos = over_q[QW] | q[QW-1];
  assign big_neg = over_q[QW] | (q[QW-1] & (|q[QW-2:0]));

  always_comb begin
    if (neg_q[QW]) begin
      res_o = big_neg ? {1'b1, {(QW-1){1'b0}}} : $signed((~q) + QW'(1));
    end else begin
      res_o = big_pos ? {1'b0, {(QW-1){1'b1}}} : $signed(q);
    end
  end

  assign valid_o = v_q[QW];

endmodule

`default_nettype wire

### hw/rtl/sprite_screen_projection_top.sv
// ----------------------------------------------------------------------------
// sprite_screen_projection_top
// Projects one sprite per request onto the screen: camera-matrix inversion,
// centre column, vertical shift, sprite size and clamped draw bounds.
// ----------------------------------------------------------------------------
// Usage
//   in channel  : in_valid_i / in_ready_o with the sprite and camera vectors
//   out channel : out_valid_o / out_ready_i with the projected result
//   config      : cfg_we_i writes cfg_data_i to register cfg_idx_i at once;
//                 write only while no request is in flight
// One request is taken every cycle while in_ready_o is high: two 32-step
// dividers (lateral, depth) and four 16-step dividers (column, shift,
// height, width) each retire one quotient bit per stage.
// Reset clears all valid bits and loads the register defaults (640 x 480,
// no vertical move, divisors of one); the pipeline is empty afterwards.
// A stalled receiver fills the output register and then a one-entry skid
// register; only then does the pipeline freeze and in_ready_o drop. Nothing
// is lost or repeated across a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_screen_projection_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire ssp_pkg::in_t                  in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output ssp_pkg::out_t                      out_req_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [ssp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ssp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import ssp_pkg::*;

  localparam int NWA = 64 + FRAC_BITS;
  localparam int DWA = 64;
  localparam int QWA = 32;
  localparam int NWC = 46;
  localparam int DWB = 32;
  localparam int QWB = 16;
  localparam int NWV = 13 + FRAC_BITS;
  localparam int NWH = 13 + FRAC_BITS;
  localparam int DWH = 37;

  // config registers
  logic        [12:0] cfg_w_q, cfg_h_q;
  logic signed [11:0] cfg_vm_q;
  logic        [4:0]  cfg_wdiv_q, cfg_hdiv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= 13'd640;
      cfg_h_q    <= 13'd480;
      cfg_vm_q   <= '0;
      cfg_wdiv_q <= 5'd1;
      cfg_hdiv_q <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCREEN_WIDTH:   cfg_w_q    <= cfg_data_i[12:0];
        CFG_SCREEN_HEIGHT:  cfg_h_q    <= cfg_data_i[12:0];
        CFG_VERTICAL_MOVE:  cfg_vm_q   <= $signed(cfg_data_i[11:0]);
        CFG_WIDTH_DIVISOR:  cfg_wdiv_q <= cfg_data_i[4:0];
        CFG_HEIGHT_DIVISOR: cfg_hdiv_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  logic skid_v_q, out_v_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // stage 1: products
  logic               s1_v_q;
  logic signed [63:0] p_det1_q, p_det2_q, p_nx1_q, p_nx2_q, p_ny1_q, p_ny2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_det1_q <= 64'(in_req_i.cam_plane_x) * 64'(in_req_i.view_dir_y);
      p_det2_q <= 64'(in_req_i.view_dir_x) * 64'(in_req_i.cam_plane_y);
      p_nx1_q  <= 64'(in_req_i.view_dir_y) * 64'(in_req_i.rel_x);
      p_nx2_q  <= 64'(in_req_i.view_dir_x) * 64'(in_req_i.rel_y);
      p_ny1_q  <= 64'(in_req_i.cam_plane_x) * 64'(in_req_i.rel_y);
      p_ny2_q  <= 64'(in_req_i.cam_plane_y) * 64'(in_req_i.rel_x);
    end
  end

  // stage 2: sign and magnitude differences
  function automatic logic [64:0] sm_diff(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] d;
    logic        [64:0] m;
    d = 65'(a) - 65'(b);
    m = d[64] ? 65'(-d) : 65'(d);
    return {d[64], m[63:0]};
  endfunction

  logic        s2_v_q;
  logic [64:0] det_d, nx_d, ny_d;
  logic [63:0] detm_q, nxm_q, nym_q;
  logic        detn_q, nxn_q, nyn_q, detz_q;

  assign det_d = sm_diff(p_det1_q, p_det2_q);
  assign nx_d  = sm_diff(p_nx1_q, p_nx2_q);
  assign ny_d  = sm_diff(p_ny1_q, p_ny2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      detm_q <= det_d[63:0];
      detn_q <= det_d[64];
      detz_q <= (det_d[63:0] == '0);
      nxm_q  <= nx_d[63:0];
      nxn_q  <= nx_d[64];
      nym_q  <= ny_d[63:0];
      nyn_q  <= ny_d[64];
    end
  end

  // lateral and depth dividers
  logic                   da_v, da_v_unused, da_dz;
  logic signed [QWA-1:0]  lat_res, dep_res;

  ssp_div #(.NW(NWA), .DW(DWA), .QW(QWA)) u_div_lat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s2_v_q),
    .num_i({nxm_q, {FRAC_BITS{1'b0}}}), .den_i(detm_q), .neg_i(nxn_q ^ detn_q),
    .valid_o(da_v), .res_o(lat_res)
  );

  ssp_div #(.NW(NWA), .DW(DWA), .QW(QWA)) u_div_dep (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s2_v_q),
    .num_i({nym_q, {FRAC_BITS{1'b0}}}), .den_i(detm_q), .neg_i(nyn_q ^ detn_q),
    .valid_o(da_v_unused), .res_o(dep_res)
  );

  ssp_delay #(.W(1), .N(QWA + 1)) u_dly_a (
    .clk_i, .en_i(en), .d_i(detz_q), .d_o(da_dz)
  );

  // stage 3: numerators and denominators of the screen quotients
  logic signed [31:0] lat, dep;
  logic signed [32:0] sum;
  logic        [32:0] sum_mag;
  logic        [31:0] adep;
  logic        [4:0]  hdiv, wdiv;
  logic        [12:0] vm_mag;

  assign lat     = da_dz ? '0 : lat_res;
  assign dep     = da_dz ? '0 : dep_res;
  assign sum     = 33'(lat) + 33'(dep);
  assign sum_mag = sum[32] ? 33'(-sum) : 33'(sum);
  assign adep    = dep[31] ? 32'(-33'(dep)) : 32'(dep);
  assign hdiv    = (cfg_hdiv_q == '0) ? 5'd1 : cfg_hdiv_q;
  assign wdiv    = (cfg_wdiv_q == '0) ? 5'd1 : cfg_wdiv_q;
  assign vm_mag  = cfg_vm_q[11] ? 13'(-13'(cfg_vm_q)) : 13'(cfg_vm_q);

  logic               s3_v_q;
  logic [NWC-1:0]     cmag_q;
  logic               cneg_q, vneg_q, latnn_q, dz_q;
  logic [31:0]        adep_q;
  logic [DWH-1:0]     hden_q, wden_q;
  logic [12:0]        vmag_q;
  logic signed [31:0] dep3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= da_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmag_q  <= NWC'({34'd0, cfg_w_q[12:1]} * {13'd0, sum_mag});
      cneg_q  <= sum[32] ^ dep[31];
      vmag_q  <= vm_mag;
      vneg_q  <= cfg_vm_q[11] ^ dep[31];
      adep_q  <= adep;
      hden_q  <= {5'd0, adep} * {32'd0, hdiv};
      wden_q  <= {5'd0, adep} * {32'd0, wdiv};
      latnn_q <= !lat[31];
      dz_q    <= (dep == '0);
      dep3_q  <= dep;
    end
  end

  // screen quotient dividers
  logic                  db_v, db_v1, db_v2, db_v3;
  logic signed [QWB-1:0] c_res, v_res, h_res, w_res;
  logic [33:0]           db_side;

  ssp_div #(.NW(NWC), .DW(DWB), .QW(QWB)) u_div_col (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s3_v_q),
    .num_i(cmag_q), .den_i(adep_q), .neg_i(cneg_q),
    .valid_o(db_v), .res_o(c_res)
  );

  ssp_div #(.NW(NWV), .DW(DWB), .QW(QWB)) u_div_vsh (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s3_v_q),
    .num_i({vmag_q, {FRAC_BITS{1'b0}}}), .den_i(adep_q), .neg_i(vneg_q),
    .valid_o(db_v1), .res_o(v_res)
  );

  ssp_div #(.NW(NWH), .DW(DWH), .QW(QWB)) u_div_hgt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s3_v_q),
    .num_i({cfg_h_q, {FRAC_BITS{1'b0}}}), .den_i(hden_q), .neg_i(1'b0),
    .valid_o(db_v2), .res_o(h_res)
  );

  ssp_div #(.NW(NWH), .DW(DWH), .QW(QWB)) u_div_wid (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s3_v_q),
    .num_i({cfg_h_q, {FRAC_BITS{1'b0}}}), .den_i(wden_q), .neg_i(1'b0),
    .valid_o(db_v3), .res_o(w_res)
  );

  ssp_delay #(.W(34), .N(QWB + 1)) u_dly_b (
    .clk_i, .en_i(en), .d_i({dep3_q, latnn_q, dz_q}), .d_o(db_side)
  );

  // stage 4: zero-depth overrides
  logic signed [31:0] b_dep;
  logic               b_latnn, b_dz, vm_pos;

  assign b_dep   = db_side[33:2];
  assign b_latnn = db_side[1];
  assign b_dz    = db_side[0];
  assign vm_pos  = !cfg_vm_q[11] && (cfg_vm_q != '0);

  logic               s4_v_q;
  logic signed [15:0] center_q, vshift_q;
  logic        [14:0] hpx_q, wpx_q;
  logic signed [31:0] dep4_q;
  logic               vis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= db_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (b_dz) begin
        center_q <= b_latnn ? 16'sh7fff : 16'sh8000;
        vshift_q <= vm_pos ? 16'sh7fff : (cfg_vm_q[11] ? 16'sh8000 : 16'sh0000);
        hpx_q    <= 15'h7fff;
        wpx_q    <= 15'h7fff;
      end else begin
        center_q <= c_res;
        vshift_q <= v_res;
        hpx_q    <= h_res[14:0];
        wpx_q    <= w_res[14:0];
      end
      dep4_q <= b_dep;
      vis_q  <= !b_dep[31] && (b_dep != '0);
    end
  end

  // draw bounds
  logic signed [17:0] top_s, bot_s, left_s, right_s, h_s, w_s;
  out_t               res;

  assign h_s     = $signed({5'd0, cfg_h_q});
  assign w_s     = $signed({5'd0, cfg_w_q});
  assign top_s   = $signed({6'd0, cfg_h_q[12:1]}) - $signed({4'd0, hpx_q[14:1]})
                   + 18'(vshift_q);
  assign bot_s   = $signed({6'd0, cfg_h_q[12:1]}) + $signed({4'd0, hpx_q[14:1]})
                   + 18'(vshift_q);
  assign left_s  = 18'(center_q) - $signed({4'd0, wpx_q[14:1]});
  assign right_s = 18'(center_q) + $signed({4'd0, wpx_q[14:1]});

  always_comb begin
    res.center_column  = center_q;
    res.vertical_shift = vshift_q;
    res.height_px      = hpx_q;
    res.width_px       = wpx_q;
    res.top_row        = top_s[17] ? 15'd0 :
                         ((top_s > 18'sd32767) ? 15'h7fff : top_s[14:0]);
    res.bottom_row     = (bot_s >= h_s) ? 16'(h_s - 18'sd1) : bot_s[15:0];
    res.left_col       = left_s[17] ? 15'd0 :
                         ((left_s > 18'sd32767) ? 15'h7fff : left_s[14:0]);
    res.right_col      = (right_s >= w_s) ? 16'(w_s - 18'sd1) : right_s[15:0];
    res.depth          = dep4_q;
    res.visible        = vis_q;
  end

  // output register and skid
  out_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= s4_v_q;
      end
    end else if (s4_v_q && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (!skid_v_q) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_req_o   = out_q;

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without an output entry");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid filled without an output stall");

  a_visible_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.visible) |->
      (!out_req_o.depth[31] && (out_req_o.depth != '0)))
    else $error("visible result with nonpositive depth");

  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (da_v == da_v_unused) && (db_v == db_v1) && (db_v == db_v2) && (db_v == db_v3))
    else $error("divider lanes out of step");

endmodule

`default_nettype wire
